FILE: src/spinning_current_hall_demodulator_assert.svh
// Assertion macros shared by the spinning-current Hall demodulator files.
`ifndef SPINNING_CURRENT_HALL_DEMODULATOR_ASSERT_SVH
`define SPINNING_CURRENT_HALL_DEMODULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SHCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SHCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SHCD_ASSERT(label, clk, rst, prop, msg)
`define SHCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: src/shcd_pkg.sv
// Shared constants and types for the spinning-current Hall demodulator.
package shcd_pkg;

   localparam int ADC_BITS        = 24;
   localparam int COUNT_WIDTH     = 16;
   localparam int SUM_WIDTH       = ADC_BITS + COUNT_WIDTH + 1;
   localparam int HALL_WIDTH      = ADC_BITS + 3;
   localparam int NUM_DIRS        = 4;
   localparam int DIR_BITS        = 2;
   localparam int DIV_STEP_BITS   = $clog2(SUM_WIDTH + 1);
   localparam int REQ_TDATA_WIDTH = ((ADC_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_WIDTH = 4;
   localparam int RSP_TDATA_WIDTH = ((HALL_WIDTH + 7) / 8) * 8;
   localparam int RSP_TUSER_WIDTH = 2;

   localparam logic [ADC_BITS-1:0]    ZERO_OFFSET_RESET = ADC_BITS'(32'h0080_0000);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX         = {COUNT_WIDTH{1'b1}};

   typedef enum logic [0:0] {
      OP_ACCUMULATE = 1'b0,
      OP_END_PERIOD = 1'b1
   } op_type;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_NORTH = 2'd0,
      DIR_SOUTH = 2'd1,
      DIR_EAST  = 2'd2,
      DIR_WEST  = 2'd3
   } dir_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] sum;
      logic [COUNT_WIDTH-1:0]      count;
   } entry_type;

endpackage

FILE: src/shcd_divider.sv
// Bit-serial restoring divider: sum magnitude by sample count, one quotient bit per cycle.
`include "spinning_current_hall_demodulator_assert.svh"

module shcd_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [shcd_pkg::SUM_WIDTH-1:0]   dividend,
   input  logic [shcd_pkg::COUNT_WIDTH-1:0] divisor,
   output logic                             busy,
   output logic                             done,
   output logic [shcd_pkg::SUM_WIDTH-1:0]   quotient
);
   import shcd_pkg::*;

   logic [SUM_WIDTH-1:0]     quot_ff;
   logic [COUNT_WIDTH-1:0]   rem_ff;
   logic [COUNT_WIDTH-1:0]   divisor_ff;
   logic [DIV_STEP_BITS-1:0] step_ff;
   logic                     busy_ff;
   logic                     done_ff;

   logic [COUNT_WIDTH:0]     trial_in;
   logic [COUNT_WIDTH:0]     diff_in;
   logic                     fits_in;
   logic [COUNT_WIDTH-1:0]   rem_in;
   logic [SUM_WIDTH-1:0]     quot_in;

   always_comb begin
      trial_in = {rem_ff, quot_ff[SUM_WIDTH-1]};
      diff_in  = trial_in - {1'b0, divisor_ff};
      fits_in  = (trial_in >= {1'b0, divisor_ff});
      rem_in   = fits_in ? diff_in[COUNT_WIDTH-1:0] : trial_in[COUNT_WIDTH-1:0];
      quot_in  = {quot_ff[SUM_WIDTH-2:0], fits_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff    <= dividend;
            rem_ff     <= '0;
            divisor_ff <= divisor;
            step_ff    <= DIV_STEP_BITS'(SUM_WIDTH);
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == DIV_STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

   `SHCD_ASSERT(a_no_restart, clock, reset, !start || !busy_ff, "divider started while busy")
   `SHCD_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "divider done held")
   `SHCD_ASSERT(a_rem_bound, clock, reset, !busy_ff || rem_ff < divisor_ff, "remainder out of range")

endmodule

FILE: src/spinning_current_hall_demodulator.sv
// Spinning-current Hall demodulator: accumulates centered ADC samples per current
// direction in a four-entry sum/count memory and, at end of period, emits
// avg_n - avg_s + avg_e - avg_w in ADC LSBs. A stable sample is read from memory,
// then added and written back; an unstable sample is accepted and not stored. An
// end-of-period request divides each direction's sum by its count, using the
// bit-serial divider that produces one quotient bit per cycle, for each of the four
// directions in turn. A direction with no samples makes the result 0 with
// valid_res low; a saturated count drops the sample and raises overflowed.
`include "spinning_current_hall_demodulator_assert.svh"

module spinning_current_hall_demodulator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [shcd_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // sample
   input  logic [shcd_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,  // operation, direction[1:0], stable
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [shcd_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,  // hall_sum
   output logic [shcd_pkg::RSP_TUSER_WIDTH-1:0] rsp_tuser,  // valid_res, overflowed
   input  logic                                 csr_wen,
   input  logic [shcd_pkg::ADC_BITS-1:0]        csr_wdata
);
   import shcd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_EOP_READ,
      ST_EOP_LOAD,
      ST_EOP_DIV,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   logic [ADC_BITS-1:0]       zero_offset_ff;
   logic [ADC_BITS-1:0]       sample_ff;
   logic [DIR_BITS-1:0]       dir_ff;
   logic [DIR_BITS-1:0]       idx_ff;
   logic [NUM_DIRS-1:0]       entry_valid_ff;
   logic                      sat_ff;
   logic                      all_valid_ff;
   logic                      neg_ff;
   logic [HALL_WIDTH-1:0]     hall_acc_ff;
   logic                      rsp_valid_ff;
   logic [HALL_WIDTH-1:0]     rsp_hall_ff;
   logic                      rsp_valid_res_ff;
   logic                      rsp_overflow_ff;

   entry_type                 entry_mem [NUM_DIRS];
   entry_type                 rd_data_ff;
   logic                      rd_valid_ff;

   op_type                    req_op;
   logic [DIR_BITS-1:0]       req_dir;
   logic                      req_stable;
   logic                      req_fire;
   logic                      rsp_room;
   logic [DIR_BITS-1:0]       rd_addr;
   entry_type                 entry_in;
   logic signed [ADC_BITS:0]  centered_in;
   logic                      mem_we;
   entry_type                 mem_wdata;
   logic                      div_start;
   logic                      div_busy;
   logic                      div_done;
   logic [SUM_WIDTH-1:0]      div_quotient;
   logic [SUM_WIDTH-1:0]      magnitude_in;
   logic [HALL_WIDTH-1:0]     term_in;
   logic [HALL_WIDTH-1:0]     hall_in;
   logic                      last_dir;

   assign req_op     = op_type'(req_tuser[0]);
   assign req_dir    = req_tuser[2:1];
   assign req_stable = req_tuser[3];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_room   = !rsp_valid_ff || rsp_tready;
   assign rd_addr    = (state_ff == ST_IDLE) ? req_dir : idx_ff;
   assign last_dir   = (idx_ff == DIR_BITS'(NUM_DIRS - 1));

   always_comb begin
      entry_in     = rd_valid_ff ? rd_data_ff : '0;
      centered_in  = $signed({1'b0, sample_ff}) - $signed({1'b0, zero_offset_ff});
      mem_wdata.sum   = entry_in.sum + SUM_WIDTH'(centered_in);
      mem_wdata.count = entry_in.count + 1'b1;
      mem_we       = (state_ff == ST_ACCUM) && (entry_in.count != COUNT_MAX);
      div_start    = (state_ff == ST_EOP_LOAD) && (entry_in.count != '0);
      magnitude_in = entry_in.sum[SUM_WIDTH-1] ? (-entry_in.sum) : entry_in.sum;
      term_in      = neg_ff ? (-div_quotient[HALL_WIDTH-1:0]) : div_quotient[HALL_WIDTH-1:0];
      if (dir_type'(idx_ff) inside {DIR_SOUTH, DIR_WEST}) begin
         hall_in = hall_acc_ff - term_in;
      end else begin
         hall_in = hall_acc_ff + term_in;
      end
   end

   // Sum/count memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[dir_ff] <= mem_wdata;
      end
      rd_data_ff  <= entry_mem[rd_addr];
      rd_valid_ff <= entry_valid_ff[rd_addr];
   end

   shcd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (magnitude_in),
      .divisor  (entry_in.count),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         zero_offset_ff <= ZERO_OFFSET_RESET;
         entry_valid_ff <= '0;
         sat_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         idx_ff         <= '0;
      end else begin
         if (csr_wen) begin
            zero_offset_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  sample_ff <= req_tdata[ADC_BITS-1:0];
                  dir_ff    <= req_dir;
                  if (req_op == OP_END_PERIOD) begin
                     idx_ff       <= '0;
                     all_valid_ff <= 1'b1;
                     hall_acc_ff  <= '0;
                     state_ff     <= ST_EOP_READ;
                  end else if (req_stable) begin
                     state_ff <= ST_ACCUM;
                  end
               end
            end
            ST_ACCUM: begin
               if (mem_we) begin
                  entry_valid_ff[dir_ff] <= 1'b1;
               end else begin
                  sat_ff <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            ST_EOP_READ: begin
               state_ff <= ST_EOP_LOAD;
            end
            ST_EOP_LOAD: begin
               neg_ff <= entry_in.sum[SUM_WIDTH-1];
               if (div_start) begin
                  state_ff <= ST_EOP_DIV;
               end else begin
                  all_valid_ff <= 1'b0;
                  idx_ff       <= idx_ff + 1'b1;
                  state_ff     <= last_dir ? ST_FINISH : ST_EOP_READ;
               end
            end
            ST_EOP_DIV: begin
               if (div_done) begin
                  hall_acc_ff <= hall_in;
                  idx_ff      <= idx_ff + 1'b1;
                  state_ff    <= last_dir ? ST_FINISH : ST_EOP_READ;
               end
            end
            ST_FINISH: begin
               if (rsp_room) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_hall_ff      <= all_valid_ff ? hall_acc_ff : '0;
                  rsp_valid_res_ff <= all_valid_ff;
                  rsp_overflow_ff  <= sat_ff;
                  entry_valid_ff   <= '0;
                  sat_ff           <= 1'b0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(rsp_hall_ff);
   assign rsp_tuser  = {rsp_overflow_ff, rsp_valid_res_ff};

   `SHCD_ASSERT_NEXT(a_accum_rmw, clock, reset, req_fire && req_op == OP_ACCUMULATE && req_stable, state_ff == ST_ACCUM, "stable sample not sent to write-back")
   `SHCD_ASSERT(a_write_in_accum, clock, reset, !mem_we || state_ff == ST_ACCUM, "memory written outside write-back")
   `SHCD_ASSERT(a_div_nonzero, clock, reset, !div_start || (entry_in.count != '0 && !div_busy), "divider started on empty count")
   `SHCD_ASSERT_NEXT(a_finish_clears, clock, reset, state_ff == ST_FINISH && rsp_room, rsp_valid_ff && entry_valid_ff == '0 && !sat_ff, "period end left state behind")

endmodule

FILE: verif/spinning_current_hall_demodulator_tb.sv
// Self-checking testbench for the spinning-current Hall demodulator stream block.
`timescale 1ns / 1ps

module spinning_current_hall_demodulator_tb;
   import shcd_pkg::*;

   typedef struct {
      op_type                op;
      logic [ADC_BITS-1:0]   sample;
      dir_type               dir;
      logic                  stable;
   } hall_request_type;

   typedef struct {
      logic [HALL_WIDTH-1:0] hall;
      logic                  valid_res;
      logic                  overflowed;
   } hall_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;  // sample
   logic [REQ_TUSER_WIDTH-1:0] req_tuser = '0;  // operation, direction[1:0], stable
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;       // hall_sum
   logic [RSP_TUSER_WIDTH-1:0] rsp_tuser;       // valid_res, overflowed
   logic                       csr_wen = 1'b0;
   logic [ADC_BITS-1:0]        csr_wdata = '0;

   spinning_current_hall_demodulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   hall_request_type    pending_requests[$];
   hall_result_type     hall_results_due[$];
   hall_request_type    held_request;
   int                  send_gap = 0;
   int                  stall_left = 0;
   bit                  idle_off = 1'b0;
   int                  failures = 0;
   int                  phase_items = 0;

   logic [ADC_BITS-1:0] offset_shadow;
   longint              dir_sum[NUM_DIRS];
   int                  dir_count[NUM_DIRS];
   bit                  count_saturated;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [ADC_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return offset_shadow + ADC_BITS'($urandom_range(0, 6)) - ADC_BITS'(3);
      return ADC_BITS'($urandom);
   endfunction

   function automatic void clear_accumulators();
      for (int i = 0; i < NUM_DIRS; i++) begin
         dir_sum[i] = 0;
         dir_count[i] = 0;
      end
      count_saturated = 1'b0;
   endfunction

   function automatic void accumulate_sample(hall_request_type rq);
      int d;
      d = int'(rq.dir);
      if (!rq.stable) return;
      if (dir_count[d] >= int'(COUNT_MAX)) begin
         count_saturated = 1'b1;
         return;
      end
      dir_sum[d] += longint'({1'b0, rq.sample}) - longint'({1'b0, offset_shadow});
      dir_count[d]++;
   endfunction

   function automatic hall_result_type close_period();
      hall_result_type res;
      longint          avg[NUM_DIRS];
      longint          acc;
      res.valid_res = 1'b1;
      res.overflowed = count_saturated;
      acc = 0;
      for (int i = 0; i < NUM_DIRS; i++)
         if (dir_count[i] == 0) res.valid_res = 1'b0;
      if (res.valid_res) begin
         for (int i = 0; i < NUM_DIRS; i++) avg[i] = dir_sum[i] / longint'(dir_count[i]);
         acc = avg[DIR_NORTH] - avg[DIR_SOUTH] + avg[DIR_EAST] - avg[DIR_WEST];
      end
      res.hall = acc[HALL_WIDTH-1:0];
      clear_accumulators();
      return res;
   endfunction

   function automatic void apply_request(hall_request_type rq);
      if (rq.op == OP_ACCUMULATE) accumulate_sample(rq);
      else hall_results_due.push_back(close_period());
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(held_request);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               held_request = pending_requests.pop_front();
               req_tdata  <= REQ_TDATA_WIDTH'(held_request.sample);
               req_tuser  <= {held_request.stable, held_request.dir, held_request.op};
               req_tvalid <= 1'b1;
               send_gap = idle_off ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      hall_result_type            want;
      logic [RSP_TDATA_WIDTH-1:0] want_tdata;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (hall_results_due.size() == 0) begin
               $display("%0t unexpected result: hall_sum %0d tuser %b", $time,
                        $signed(rsp_tdata[HALL_WIDTH-1:0]), rsp_tuser);
               failures++;
            end else begin
               want = hall_results_due.pop_front();
               want_tdata = '0;
               want_tdata[HALL_WIDTH-1:0] = want.hall;
               if (rsp_tdata !== want_tdata) begin
                  $display("%0t hall_sum: expected %0d (%h) actual %0d (%h)", $time,
                           $signed(want.hall), want_tdata,
                           $signed(rsp_tdata[HALL_WIDTH-1:0]), rsp_tdata);
                  failures++;
               end
               if (rsp_tuser[0] !== want.valid_res) begin
                  $display("%0t valid_res: expected %b actual %b", $time,
                           want.valid_res, rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tuser[1] !== want.overflowed) begin
                  $display("%0t overflowed: expected %b actual %b", $time,
                           want.overflowed, rsp_tuser[1]);
                  failures++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!idle_off && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   task automatic push_request(op_type op, logic [ADC_BITS-1:0] sample, dir_type dir,
                               logic stable);
      hall_request_type rq;
      rq.op = op;
      rq.sample = sample;
      rq.dir = dir;
      rq.stable = stable;
      pending_requests.push_back(rq);
      phase_items++;
   endtask

   task automatic push_end();
      push_request(OP_END_PERIOD, ADC_BITS'($urandom), dir_type'($urandom_range(0, 3)),
                   1'($urandom));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || hall_results_due.size() != 0);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_offset(logic [ADC_BITS-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      offset_shadow = value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_random_period();
      int r;
      int n;
      int first;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         first = $urandom_range(0, 3);
         for (int i = 0; i < NUM_DIRS; i++)
            push_request(OP_ACCUMULATE, pick_sample(), dir_type'((first + i) % NUM_DIRS), 1'b1);
         n = $urandom_range(0, 36);
         for (int i = 0; i < n; i++)
            push_request(OP_ACCUMULATE, pick_sample(), dir_type'($urandom_range(0, 3)),
                         $urandom_range(0, 9) != 0);
         push_end();
      end else if (r < 90) begin
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i++)
            push_request(OP_ACCUMULATE, pick_sample(), dir_type'($urandom_range(0, 3)),
                         $urandom_range(0, 4) != 0);
         push_end();
      end else begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            push_request($urandom_range(0, 5) == 0 ? OP_END_PERIOD : OP_ACCUMULATE,
                         ADC_BITS'($urandom), dir_type'($urandom_range(0, 3)), 1'($urandom));
      end
   endtask

   initial begin
      logic [ADC_BITS-1:0] phase_offset[6];
      offset_shadow = ZERO_OFFSET_RESET;
      clear_accumulators();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset offset: mixed period, empty period, period missing west
      push_request(OP_ACCUMULATE, '1, DIR_NORTH, 1'b1);
      push_request(OP_ACCUMULATE, '0, DIR_SOUTH, 1'b1);
      push_request(OP_ACCUMULATE, ZERO_OFFSET_RESET, DIR_EAST, 1'b1);
      push_request(OP_ACCUMULATE, ZERO_OFFSET_RESET - 1'b1, DIR_WEST, 1'b1);
      push_request(OP_ACCUMULATE, '0, DIR_NORTH, 1'b0);
      push_request(OP_END_PERIOD, '0, DIR_NORTH, 1'b0);
      push_request(OP_END_PERIOD, '1, DIR_WEST, 1'b1);
      push_request(OP_ACCUMULATE, 24'h123456, DIR_NORTH, 1'b1);
      push_request(OP_ACCUMULATE, 24'hABCDEF, DIR_SOUTH, 1'b1);
      push_request(OP_ACCUMULATE, 24'h000001, DIR_EAST, 1'b1);
      push_request(OP_ACCUMULATE, 24'hFEDCBA, DIR_WEST, 1'b0);
      push_request(OP_END_PERIOD, '1, DIR_EAST, 1'b1);
      wait_drained();

      write_offset('0);
      push_request(OP_ACCUMULATE, '1, DIR_NORTH, 1'b1);
      push_request(OP_ACCUMULATE, '0, DIR_SOUTH, 1'b1);
      push_request(OP_ACCUMULATE, '1, DIR_EAST, 1'b1);
      push_request(OP_ACCUMULATE, '0, DIR_WEST, 1'b1);
      push_request(OP_END_PERIOD, '0, DIR_SOUTH, 1'b1);
      wait_drained();

      // negative sums with truncation toward zero
      write_offset('1);
      push_request(OP_ACCUMULATE, '0, DIR_NORTH, 1'b1);
      push_request(OP_ACCUMULATE, 24'h000001, DIR_NORTH, 1'b1);
      push_request(OP_ACCUMULATE, '1, DIR_SOUTH, 1'b1);
      push_request(OP_ACCUMULATE, '0, DIR_EAST, 1'b1);
      push_request(OP_ACCUMULATE, '1, DIR_WEST, 1'b1);
      push_request(OP_END_PERIOD, '0, DIR_NORTH, 1'b0);
      wait_drained();

      phase_offset[0] = '0;
      phase_offset[1] = '1;
      phase_offset[2] = ZERO_OFFSET_RESET;
      phase_offset[3] = ADC_BITS'($urandom);
      phase_offset[4] = ADC_BITS'($urandom);
      phase_offset[5] = 24'h7FFFFF;
      foreach (phase_offset[p]) begin
         write_offset(phase_offset[p]);
         idle_off = ($urandom_range(0, 3) == 0);
         phase_items = 0;
         while (phase_items < 300) push_random_period();
         push_end();
         wait_drained();
      end

      repeat (200) @(negedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
